[sv/assert_macros.svh]
// Assertion macros used by the list store RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expr holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("invariant violated");

// cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sequence violated");

`endif

[sv/ilist_pkg.sv]
// Package: sizes, codes, payload types and capacity policy of the list store.
package ilist_pkg;

    localparam int DEPTH      = 64;
    localparam int WORD_WIDTH = 32;
    localparam int IDX_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);
    localparam int MODE_W     = 3;
    localparam int POS_W      = 7;
    localparam int CFG_W      = 7;
    localparam int FOUND_W    = 6;
    localparam int STAT_W     = 2;

    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);
    localparam logic [CNT_W-1:0] CAP_MIN   = CNT_W'(2);

    localparam logic [MODE_W-1:0] MODE_APPEND = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_INSERT = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_DELETE = MODE_W'(2);
    localparam logic [MODE_W-1:0] MODE_SEARCH = MODE_W'(3);
    localparam logic [MODE_W-1:0] MODE_CLEAR  = MODE_W'(4);

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2,
        ST_MISS  = 2'd3
    } status_t;

    typedef struct packed {
        logic [MODE_W-1:0]            mode;
        logic [POS_W-1:0]             position;
        logic signed [WORD_WIDTH-1:0] item_value;
    } cmd_t;

    typedef struct packed {
        status_t                      status;
        logic [FOUND_W-1:0]           found_index;
        logic signed [WORD_WIDTH-1:0] removed_value;
        logic [CNT_W-1:0]             fill_count;
        logic [CNT_W-1:0]             logical_capacity;
    } rsp_t;

    // capacity doubles when full, capped at DEPTH
    function automatic logic [CNT_W-1:0] grow_cap(input logic [CNT_W-1:0] cnt,
                                                  input logic [CNT_W-1:0] cap);
        logic [CNT_W:0] dbl;
        dbl = {cap, 1'b0};
        if (cnt >= cap)
        begin
            if (dbl > (CNT_W + 1)'(DEPTH))
                return DEPTH_CNT;
            else
                return dbl[CNT_W-1:0];
        end
        return cap;
    endfunction

    // capacity halves when fill drops below a quarter, not below CAP_MIN
    function automatic logic [CNT_W-1:0] shrink_cap(input logic [CNT_W-1:0] cnt,
                                                    input logic [CNT_W-1:0] cap);
        logic [CNT_W-1:0] n;
        n = cap >> 1;
        if (cap > CAP_MIN && cnt < (cap >> 2))
        begin
            if (n < CAP_MIN)
                n = CAP_MIN;
            if (n < cnt)
                n = cnt;
            return n;
        end
        return cap;
    endfunction

    function automatic logic [CNT_W-1:0] clamp_cap(input logic [CFG_W-1:0] init);
        if (init == '0)
            return CNT_W'(1);
        if (CNT_W'(init) > DEPTH_CNT)
            return DEPTH_CNT;
        return CNT_W'(init);
    endfunction

endpackage

[sv/ilist_cmd_if.sv]
// Command channel: mode, position and value with valid/ready.
interface ilist_cmd_if;
    logic                                       valid;
    logic                                       ready;
    logic [ilist_pkg::MODE_W-1:0]               mode;
    logic [ilist_pkg::POS_W-1:0]                position;
    logic signed [ilist_pkg::WORD_WIDTH-1:0]    item_value;

    modport source (output valid, output mode, output position, output item_value,
                    input ready);
    modport sink (input valid, input mode, input position, input item_value,
                  output ready);
endinterface

[sv/ilist_rsp_if.sv]
// Result channel: status, index, removed value, fill and capacity with valid/ready.
interface ilist_rsp_if;
    logic                                       valid;
    logic                                       ready;
    logic [ilist_pkg::STAT_W-1:0]               status;
    logic [ilist_pkg::FOUND_W-1:0]              found_index;
    logic signed [ilist_pkg::WORD_WIDTH-1:0]    removed_value;
    logic [ilist_pkg::CNT_W-1:0]                fill_count;
    logic [ilist_pkg::CNT_W-1:0]                logical_capacity;

    modport source (output valid, output status, output found_index, output removed_value,
                    output fill_count, output logical_capacity, input ready);
    modport sink (input valid, input status, input found_index, input removed_value,
                  input fill_count, input logical_capacity, output ready);
endinterface

[sv/ilist_cfg_if.sv]
// Configuration write channel: initial capacity with valid/ready.
interface ilist_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [ilist_pkg::CFG_W-1:0]    initial_capacity;

    modport source (output valid, output initial_capacity, input ready);
    modport sink (input valid, input initial_capacity, output ready);
endinterface

[sv/ilist_ram.sv]
// Entry store: one write port, one registered read port.
module ilist_ram (
    input  logic                                    clk,
    input  logic                                    we,
    input  logic [ilist_pkg::IDX_W-1:0]             waddr,
    input  logic signed [ilist_pkg::WORD_WIDTH-1:0] wdata,
    input  logic [ilist_pkg::IDX_W-1:0]             raddr,
    output logic signed [ilist_pkg::WORD_WIDTH-1:0] rdata
);

    logic signed [ilist_pkg::WORD_WIDTH-1:0] mem [ilist_pkg::DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

[sv/ilist_ctrl.sv]
// Command sequencer: shifts, searches and capacity policy over the entry store.
`include "assert_macros.svh"

module ilist_ctrl (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cmd_valid,
    output logic                            cmd_ready,
    input  ilist_pkg::cmd_t                 cmd_data,
    input  logic [ilist_pkg::CFG_W-1:0]     init_cap,
    input  logic                            slot_free,
    output logic                            done,
    output ilist_pkg::rsp_t                 result
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_UP_RD,
        S_UP_WR,
        S_DEL_GET,
        S_DN_RD,
        S_DN_WR,
        S_SR_RD,
        S_SR_CMP,
        S_DONE
    } state_t;

    state_t                                 state_reg, state_next;
    logic [ilist_pkg::POS_W-1:0]            pos_reg, pos_next;
    logic signed [ilist_pkg::WORD_WIDTH-1:0] val_reg, val_next;
    logic [ilist_pkg::CNT_W-1:0]            cnt_reg, cnt_next;
    logic [ilist_pkg::CNT_W-1:0]            cap_reg, cap_next;
    logic [ilist_pkg::CNT_W-1:0]            idx_reg, idx_next;
    ilist_pkg::status_t                     status_reg, status_next;
    logic [ilist_pkg::FOUND_W-1:0]          found_reg, found_next;
    logic signed [ilist_pkg::WORD_WIDTH-1:0] removed_reg, removed_next;

    logic                                   ram_we;
    logic [ilist_pkg::IDX_W-1:0]            ram_waddr;
    logic signed [ilist_pkg::WORD_WIDTH-1:0] ram_wdata;
    logic [ilist_pkg::IDX_W-1:0]            ram_raddr;
    logic signed [ilist_pkg::WORD_WIDTH-1:0] ram_rdata;

    logic [ilist_pkg::CNT_W-1:0]            idx_dec;
    logic [ilist_pkg::CNT_W-1:0]            idx_inc;
    logic [ilist_pkg::CNT_W-1:0]            cnt_dec;

    ilist_ram u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign idx_dec   = idx_reg - 1'b1;
    assign idx_inc   = idx_reg + 1'b1;
    assign cnt_dec   = cnt_reg - 1'b1;
    assign cmd_ready = (state_reg == S_IDLE);

    assign result.status           = status_reg;
    assign result.found_index      = found_reg;
    assign result.removed_value    = removed_reg;
    assign result.fill_count       = cnt_reg;
    assign result.logical_capacity = cap_reg;

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        val_next     = val_reg;
        cnt_next     = cnt_reg;
        cap_next     = cap_reg;
        idx_next     = idx_reg;
        status_next  = status_reg;
        found_next   = found_reg;
        removed_next = removed_reg;
        ram_we       = 1'b0;
        ram_waddr    = idx_reg[ilist_pkg::IDX_W-1:0];
        ram_wdata    = val_reg;
        ram_raddr    = idx_reg[ilist_pkg::IDX_W-1:0];
        done         = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid)
                begin
                    pos_next     = cmd_data.position;
                    val_next     = cmd_data.item_value;
                    status_next  = ilist_pkg::ST_OK;
                    found_next   = '0;
                    removed_next = '0;
                    state_next   = S_DONE;
                    unique case (cmd_data.mode)
                        ilist_pkg::MODE_APPEND:
                        begin
                            if (cnt_reg == ilist_pkg::DEPTH_CNT)
                                status_next = ilist_pkg::ST_FULL;
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = cnt_reg[ilist_pkg::IDX_W-1:0];
                                ram_wdata = cmd_data.item_value;
                                cap_next  = ilist_pkg::grow_cap(cnt_reg, cap_reg);
                                cnt_next  = cnt_reg + 1'b1;
                            end
                        end
                        ilist_pkg::MODE_INSERT:
                        begin
                            if (cmd_data.position > cnt_reg)
                                status_next = ilist_pkg::ST_RANGE;
                            else if (cnt_reg == ilist_pkg::DEPTH_CNT)
                                status_next = ilist_pkg::ST_FULL;
                            else
                            begin
                                cap_next   = ilist_pkg::grow_cap(cnt_reg, cap_reg);
                                idx_next   = cnt_reg;
                                state_next = S_UP_RD;
                            end
                        end
                        ilist_pkg::MODE_DELETE:
                        begin
                            if (cmd_data.position >= cnt_reg)
                                status_next = ilist_pkg::ST_RANGE;
                            else
                            begin
                                ram_raddr  = cmd_data.position[ilist_pkg::IDX_W-1:0];
                                idx_next   = cmd_data.position;
                                state_next = S_DEL_GET;
                            end
                        end
                        ilist_pkg::MODE_SEARCH:
                        begin
                            status_next = ilist_pkg::ST_MISS;
                            idx_next    = '0;
                            state_next  = S_SR_RD;
                        end
                        ilist_pkg::MODE_CLEAR:
                        begin
                            cnt_next = '0;
                            cap_next = ilist_pkg::clamp_cap(init_cap);
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_UP_RD:
            begin
                if (idx_reg == pos_reg)
                begin
                    ram_we     = 1'b1;
                    ram_waddr  = pos_reg[ilist_pkg::IDX_W-1:0];
                    cnt_next   = cnt_reg + 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = idx_dec[ilist_pkg::IDX_W-1:0];
                    state_next = S_UP_WR;
                end
            end
            S_UP_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                idx_next   = idx_dec;
                state_next = S_UP_RD;
            end
            S_DEL_GET:
            begin
                removed_next = ram_rdata;
                state_next   = S_DN_RD;
            end
            S_DN_RD:
            begin
                if (idx_inc >= cnt_reg)
                begin
                    cnt_next   = cnt_dec;
                    cap_next   = ilist_pkg::shrink_cap(cnt_dec, cap_reg);
                    state_next = S_DONE;
                end
                else
                begin
                    ram_raddr  = idx_inc[ilist_pkg::IDX_W-1:0];
                    state_next = S_DN_WR;
                end
            end
            S_DN_WR:
            begin
                ram_we     = 1'b1;
                ram_wdata  = ram_rdata;
                idx_next   = idx_inc;
                state_next = S_DN_RD;
            end
            S_SR_RD:
            begin
                if (idx_reg >= cnt_reg)
                    state_next = S_DONE;
                else
                    state_next = S_SR_CMP;
            end
            S_SR_CMP:
            begin
                if (ram_rdata == val_reg)
                begin
                    status_next = ilist_pkg::ST_OK;
                    found_next  = idx_reg[ilist_pkg::FOUND_W-1:0];
                    state_next  = S_DONE;
                end
                else
                begin
                    idx_next   = idx_inc;
                    state_next = S_SR_RD;
                end
            end
            S_DONE:
            begin
                if (slot_free)
                begin
                    done       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            pos_reg     <= '0;
            val_reg     <= '0;
            cnt_reg     <= '0;
            cap_reg     <= ilist_pkg::clamp_cap(ilist_pkg::CFG_W'(2));
            idx_reg     <= '0;
            status_reg  <= ilist_pkg::ST_OK;
            found_reg   <= '0;
            removed_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            pos_reg     <= pos_next;
            val_reg     <= val_next;
            cnt_reg     <= cnt_next;
            cap_reg     <= cap_next;
            idx_reg     <= idx_next;
            status_reg  <= status_next;
            found_reg   <= found_next;
            removed_reg <= removed_next;
        end
    end

    `ASSERT_ALWAYS(a_fill_max, clk, rst_n, cnt_reg <= ilist_pkg::DEPTH_CNT)
    `ASSERT_ALWAYS(a_fill_le_cap, clk, rst_n, cnt_reg <= cap_reg)
    `ASSERT_ALWAYS(a_cap_range, clk, rst_n, cap_reg != '0 && cap_reg <= ilist_pkg::DEPTH_CNT)
    `ASSERT_NEXT(a_busy_after_accept, clk, rst_n, cmd_valid && cmd_ready, !cmd_ready)
    `ASSERT_NEXT(a_idle_after_done, clk, rst_n, done, cmd_ready)

endmodule

[sv/indexed_list_insert_delete_search_core.sv]
// Append, clear and refused commands are handled when taken; insert shifts entries up from
// the fill end to the position, delete reads the removed entry and shifts entries down,
// search reads and compares entries from index 0 until a hit or the fill; each move or
// compare waits on the registered read of the entry store. One command in flight; a
// finished result waits in the output register while the next command is taken.
// Reset (rst_n, async low): list empty, capacity 2, initial capacity register 2.
module indexed_list_insert_delete_search_core (
    input  logic            clk,
    input  logic            rst_n,
    ilist_cmd_if.sink       cmd,
    ilist_rsp_if.source     rsp,
    ilist_cfg_if.sink       cfg
);

    logic [ilist_pkg::CFG_W-1:0]    init_cap_reg;
    logic                           rsp_valid_reg;
    ilist_pkg::rsp_t                rsp_data_reg;

    ilist_pkg::cmd_t                cmd_data;
    ilist_pkg::rsp_t                result;
    logic                           done;
    logic                           slot_free;

    assign cmd_data.mode       = cmd.mode;
    assign cmd_data.position   = cmd.position;
    assign cmd_data.item_value = cmd.item_value;

    assign slot_free = !rsp_valid_reg || rsp.ready;
    assign cfg.ready = 1'b1;

    ilist_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd.valid),
        .cmd_ready (cmd.ready),
        .cmd_data  (cmd_data),
        .init_cap  (init_cap_reg),
        .slot_free (slot_free),
        .done      (done),
        .result    (result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            init_cap_reg <= ilist_pkg::CFG_W'(2);
        else if (cfg.valid)
            init_cap_reg <= cfg.initial_capacity;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
            rsp_data_reg  <= '0;
        end
        else if (done)
        begin
            rsp_valid_reg <= 1'b1;
            rsp_data_reg  <= result;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    assign rsp.valid            = rsp_valid_reg;
    assign rsp.status           = rsp_data_reg.status;
    assign rsp.found_index      = rsp_data_reg.found_index;
    assign rsp.removed_value    = rsp_data_reg.removed_value;
    assign rsp.fill_count       = rsp_data_reg.fill_count;
    assign rsp.logical_capacity = rsp_data_reg.logical_capacity;

endmodule
